[design/aes128_cbc_cipher_unit_defines.svh]
// ----------------------------------------------------------------------------
// AES-128 CBC cipher unit assertion macros
// Shared property macros for the cipher unit checks.
// ----------------------------------------------------------------------------
`ifndef AES128_CBC_CIPHER_UNIT_DEFINES_SVH
`define AES128_CBC_CIPHER_UNIT_DEFINES_SVH

// Implication check with an asynchronous active-low reset.
`define ACU_ASSERT_IMPL(label, clk_sig, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check.
`define ACU_ASSERT_NEXT(label, clk_sig, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/acu_pkg.sv]
// ----------------------------------------------------------------------------
// AES-128 CBC cipher unit package
// Constants, types and the byte-level AES functions shared by the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package acu_pkg;

	localparam int unsigned BLOCK_BYTES = 16;
	localparam int unsigned ROUNDS      = 10;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned ROUND_W     = 4;
	localparam int unsigned RK_DEPTH    = 22;
	localparam int unsigned RK_ADDR_W   = 5;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT  = 3'd4;

	typedef enum logic [2:0] {
		ST_KEYEXP,
		ST_IDLE,
		ST_INIT,
		ST_ROUND,
		ST_DONE
	} state_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a_in, input logic [7:0] b_in);
		logic [7:0] p;
		logic [7:0] a;
		p = 8'h00;
		a = a_in;
		for (int i = 0; i < 8; i++) begin
			if (b_in[i]) p = p ^ a;
			a = xtime(a);
		end
		return p;
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return t[x];
	endfunction

	// State is held as a 128-bit word, byte 0 in bits 127:120.
	function automatic logic [7:0] get_byte(input logic [127:0] s, input int unsigned i);
		return s[127-8*i -: 8];
	endfunction

	function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic last);
		logic [127:0] t;
		logic [127:0] m;
		logic [7:0]   a0, a1, a2, a3;
		t = '0;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c+r)%4)));
		m = t;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(t, 4*c); a1 = get_byte(t, 4*c+1);
			a2 = get_byte(t, 4*c+2); a3 = get_byte(t, 4*c+3);
			m[127-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			m[127-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			m[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			m[127-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return last ? t : m;
	endfunction

	// Inverse round in the order inv_shift/inv_sub, add key, inv_mix.
	function automatic logic [127:0] inv_round(input logic [127:0] s, input logic [127:0] rk,
			input logic last);
		logic [127:0] t;
		logic [127:0] m;
		logic [7:0]   a0, a1, a2, a3;
		t = '0;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127-8*(r+4*((c+r)%4)) -: 8] = inv_sbox(get_byte(s, r + 4*c));
		t = t ^ rk;
		m = t;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(t, 4*c); a1 = get_byte(t, 4*c+1);
			a2 = get_byte(t, 4*c+2); a3 = get_byte(t, 4*c+3);
			m[127-8*(4*c)   -: 8] = gmul(8'd14,a0)^gmul(8'd11,a1)^gmul(8'd13,a2)^gmul(8'd9,a3);
			m[127-8*(4*c+1) -: 8] = gmul(8'd9,a0)^gmul(8'd14,a1)^gmul(8'd11,a2)^gmul(8'd13,a3);
			m[127-8*(4*c+2) -: 8] = gmul(8'd13,a0)^gmul(8'd9,a1)^gmul(8'd14,a2)^gmul(8'd11,a3);
			m[127-8*(4*c+3) -: 8] = gmul(8'd11,a0)^gmul(8'd13,a1)^gmul(8'd9,a2)^gmul(8'd14,a3);
		end
		return last ? t : m;
	endfunction

	// One key schedule step: next round key from the previous one.
	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rcon);
		logic [31:0] t;
		logic [31:0] w0, w1, w2, w3;
		t  = {sbox(k[23:16]), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
		t  = t ^ {rcon, 24'h0};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

`default_nettype wire

[design/acu_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acu_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 11,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

[design/aes128_cbc_cipher_unit.sv]
// ----------------------------------------------------------------------------
// AES-128 CBC cipher unit
// Iterative AES-128 encrypt/decrypt core with CBC chaining, one round a cycle.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  s_axis   | in        | tdata = block_high, block_low, valid_bytes; tuser = first_block; tlast
//  m_axis   | out       | tdata = result_high, result_low; tlast = result_last
//  cfg      | in        | cfg_index (register index), cfg_data (64-bit value)
//
//  After reset the key schedule is built; a key write in idle or during the build
//  rebuilds it. During that time no block is accepted.
//  A block's transaction is followed by ST_INIT for the initial key addition and
//  then by ST_ROUND, where the single shared round unit runs the rounds.
//  The result waits in an output register, so the next block can be accepted
//  while it waits; no new block is taken before the last one's rounds are done.
//  If the previous result is still waiting when a block finishes, the unit holds
//  the new result and accepts no block until m_axis takes the old one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aes128_cbc_cipher_unit_defines.svh"

module aes128_cbc_cipher_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// Fields from bit 0: block_high [63:0], block_low [127:64], valid_bytes [132:128].
	input  wire logic [135:0]                  s_axis_tdata,
	// Fields from bit 0: first_block.
	input  wire logic                          s_axis_tuser,
	input  wire logic                          s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// Fields from bit 0: result_high [63:0], result_low [127:64].
	output logic      [127:0]                  m_axis_tdata,
	output logic                               m_axis_tlast,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [acu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                   cfg_data
);

	import acu_pkg::*;

	state_t state_q, state_d;

	logic [63:0]  key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic         decrypt_q;
	logic [127:0] chain_q;
	logic [127:0] data_q;
	logic [127:0] blk_q;
	logic         last_q;
	logic [ROUND_W-1:0] round_q;
	logic [127:0] kexp_q;
	logic [7:0]   rcon_q;
	logic         out_valid_q;
	logic [127:0] out_data_q;
	logic         out_last_q;

	logic         rk_wr;
	logic [ROUND_W-1:0] rk_wr_addr;
	logic [ROUND_W-1:0] rk_rd_addr;
	logic [127:0] rk_rd;

	logic [127:0] in_blk;
	logic [127:0] in_mask;
	logic [4:0]   vb;
	logic         s_acc, m_acc, cfg_acc, key_wr;
	logic         final_round;
	logic [127:0] round_out;
	logic [127:0] final_blk;
	logic         out_free, out_load;

	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign m_acc   = m_axis_tvalid && m_axis_tready;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign cfg_ready = 1'b1;
	assign key_wr  = cfg_acc && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

	// Input block with bytes at or beyond valid_bytes zeroed; counts above 16 keep all.
	assign vb = s_axis_tdata[132:128];
	always_comb begin
		for (int i = 0; i < 16; i++)
			in_mask[127-8*i -: 8] = (vb > 5'(i)) ? 8'hff : 8'h00;
		in_blk = {s_axis_tdata[63:0], s_axis_tdata[127:64]} & in_mask;
	end

	// Round keys live in an 11-entry RAM, written once per schedule step.
	assign rk_wr      = (state_q == ST_KEYEXP);
	assign rk_wr_addr = round_q;

	acu_ram #(.WIDTH(128), .DEPTH(ROUNDS + 1)) u_rk_ram (
		.clk     (clk),
		.wr_en   (rk_wr),
		.wr_addr (rk_wr_addr),
		.wr_data (kexp_q),
		.rd_addr (rk_rd_addr),
		.rd_data (rk_rd)
	);

	// The read address leads the round counter by one so data arrives in time.
	always_comb begin
		rk_rd_addr = '0;
		if (state_q == ST_IDLE) begin
			rk_rd_addr = decrypt_q ? ROUND_W'(ROUNDS) : '0;
		end else if (state_q == ST_INIT || state_q == ST_ROUND) begin
			rk_rd_addr = decrypt_q ? ROUND_W'(ROUNDS) - round_q - ROUND_W'(1)
				: round_q + ROUND_W'(1);
		end
	end

	assign final_round = (round_q == ROUND_W'(ROUNDS));
	always_comb begin
		if (decrypt_q) round_out = inv_round(data_q, rk_rd, final_round);
		else           round_out = fwd_round(data_q, final_round) ^ rk_rd;
	end

	// Decryption folds the chain value into the last round's output.
	assign final_blk = decrypt_q ? (round_out ^ chain_q) : round_out;

	// The output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || m_acc;
	assign out_load = out_free
		&& ((state_q == ST_ROUND && final_round) || state_q == ST_DONE);

	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_KEYEXP: if (final_round && !key_wr) state_d = ST_IDLE;
			ST_IDLE: begin
				s_axis_tready = !cfg_valid;
				if (key_wr) state_d = ST_KEYEXP;
				else if (s_acc) state_d = ST_INIT;
			end
			ST_INIT:  state_d = ST_ROUND;
			ST_ROUND: if (final_round) state_d = out_free ? ST_IDLE : ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_KEYEXP;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (m_acc)    out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
			decrypt_q  <= 1'b0;
			chain_q    <= '0;
			round_q    <= '0;
			kexp_q     <= '0;
			rcon_q     <= 8'h01;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_KEY_HIGH: key_high_q <= cfg_data;
					REG_KEY_LOW:  key_low_q  <= cfg_data;
					REG_IV_HIGH:  iv_high_q  <= cfg_data;
					REG_IV_LOW:   iv_low_q   <= cfg_data;
					REG_DECRYPT:  decrypt_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (key_wr) begin
				round_q <= '0;
				rcon_q  <= 8'h01;
				kexp_q  <= (cfg_index == REG_KEY_HIGH) ? {cfg_data, key_low_q}
					: {key_high_q, cfg_data};
			end else begin
				unique case (state_q)
					ST_KEYEXP: begin
						kexp_q  <= next_key(kexp_q, rcon_q);
						rcon_q  <= xtime(rcon_q);
						round_q <= final_round ? '0 : round_q + ROUND_W'(1);
					end
					ST_IDLE: begin
						if (s_acc) begin
							round_q <= '0;
							if (s_axis_tuser) chain_q <= {iv_high_q, iv_low_q};
						end
					end
					ST_INIT: round_q <= ROUND_W'(1);
					ST_ROUND: begin
						round_q <= round_q + ROUND_W'(1);
						if (final_round)
							chain_q <= decrypt_q ? blk_q : round_out;
					end
					ST_DONE: round_q <= '0;
					default: ;
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_acc) begin
			blk_q  <= in_blk;
			last_q <= s_axis_tlast;
		end
		unique case (state_q)
			ST_INIT: data_q <= decrypt_q ? (blk_q ^ rk_rd) : (blk_q ^ chain_q ^ rk_rd);
			ST_ROUND: data_q <= final_round ? final_blk : round_out;
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= (state_q == ST_DONE) ? data_q : final_blk;
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_data_q[63:0], out_data_q[127:64]};
	assign m_axis_tlast  = out_last_q;

	`ACU_ASSERT_IMPL(a_no_in_when_busy, clk, arst_n, state_q != ST_IDLE, !s_axis_tready,
		"input ready outside idle")
	`ACU_ASSERT_NEXT(a_accept_starts, clk, arst_n, s_acc && !key_wr, state_q == ST_INIT,
		"accepted block did not start")
	`ACU_ASSERT_NEXT(a_result_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(out_data_q), "result changed while stalled")

endmodule

`default_nettype wire

[tb/sv/aes128_cbc_cipher_checker.sv]
// ----------------------------------------------------------------------------
// AES-128 CBC cipher unit checker
// Watches the configuration, block and result channels. It predicts every
// result block with its own AES-128 CBC model and compares each result with
// the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_cbc_cipher_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	input  wire logic                          s_axis_tready,
	input  wire logic [135:0]                  s_axis_tdata,
	input  wire logic                          s_axis_tuser,
	input  wire logic                          s_axis_tlast,
	input  wire logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	input  wire logic [127:0]                  m_axis_tdata,
	input  wire logic                          m_axis_tlast,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [acu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                   cfg_data,
	output int                                 errors,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import acu_pkg::*;

	typedef struct {
		logic [63:0] res_hi;
		logic [63:0] res_lo;
		logic        res_last;
	} cipher_out_t;

	cipher_out_t blocks_due[$];

	logic [7:0]   fwd_tab [256];
	logic [7:0]   rev_tab [256];
	logic [127:0] key_word;
	logic [127:0] iv_word;
	logic         decrypt_on;
	logic [127:0] chain_word;

	function automatic logic [7:0] dbl(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = dbl(a);
		end
		return p;
	endfunction

	function automatic logic [7:0] rotb(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
		return s[127-8*i -: 8];
	endfunction

	// The substitution tables are derived from the field inverse, not typed in.
	initial begin
		logic [7:0] inv, base;
		for (int x = 0; x < 256; x++) begin
			inv = 1;
			base = x[7:0];
			for (int e = 0; e < 8; e++) begin
				if (e != 0) inv = gf_mul(inv, base);
				base = gf_mul(base, base);
			end
			// x^254 = x^2 * x^4 * ... * x^128
			fwd_tab[x] = inv ^ rotb(inv, 1) ^ rotb(inv, 2) ^ rotb(inv, 3) ^ rotb(inv, 4) ^ 8'h63;
		end
		for (int x = 0; x < 256; x++) rev_tab[fwd_tab[x]] = x[7:0];
	end

	function automatic void key_schedule(input logic [127:0] k, output logic [127:0] rk [11]);
		logic [31:0] w [44];
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 1;
		for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
		for (int i = 4; i < 44; i++) begin
			t = w[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
				t ^= {rc, 24'h0};
				rc = dbl(rc);
			end
			w[i] = w[i-4] ^ t;
		end
		for (int r = 0; r < 11; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
	endfunction

	function automatic logic [127:0] mix(input logic [127:0] s, input logic inverse);
		logic [127:0] o;
		logic [7:0]   m [4];
		logic [7:0]   acc;
		if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
		else m = '{8'd2, 8'd3, 8'd1, 8'd1};
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				acc = 0;
				for (int j = 0; j < 4; j++) acc ^= gf_mul(m[(j - r + 4) % 4], byte_at(s, 4*c + j));
				o[127-8*(4*c+r) -: 8] = acc;
			end
		return o;
	endfunction

	function automatic logic [127:0] aes_forward(input logic [127:0] s, input logic [127:0] rk [11]);
		logic [127:0] t;
		s ^= rk[0];
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[127-8*(r+4*c) -: 8] = fwd_tab[byte_at(s, r + 4*((c+r)%4))];
			s = (rnd == 10) ? t : mix(t, 1'b0);
			s ^= rk[rnd];
		end
		return s;
	endfunction

	function automatic logic [127:0] aes_inverse(input logic [127:0] s, input logic [127:0] rk [11]);
		logic [127:0] t;
		s ^= rk[10];
		for (int rnd = 9; rnd >= 0; rnd--) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[127-8*(r+4*((c+r)%4)) -: 8] = rev_tab[byte_at(s, r + 4*c)];
			t ^= rk[rnd];
			s = (rnd == 0) ? t : mix(t, 1'b1);
		end
		return s;
	endfunction

	// One CBC step: returns the result block and advances the chain.
	function automatic cipher_out_t cbc_step(input logic [127:0] blk, input logic [4:0] nbytes,
			input logic first, input logic last);
		logic [127:0] rk [11];
		logic [127:0] work;
		cipher_out_t  res;
		int           keep;
		keep = (nbytes > 16) ? 16 : nbytes;
		for (int i = keep; i < 16; i++) blk[127-8*i -: 8] = 8'h00;
		if (first) chain_word = iv_word;
		key_schedule(key_word, rk);
		if (decrypt_on) begin
			work = aes_inverse(blk, rk) ^ chain_word;
			chain_word = blk;
		end else begin
			work = aes_forward(blk ^ chain_word, rk);
			chain_word = work;
		end
		res.res_hi = work[127:64];
		res.res_lo = work[63:0];
		res.res_last = last;
		return res;
	endfunction

	assign pending = blocks_due.size();

	always @(posedge clk or negedge arst_n) begin
		cipher_out_t want;
		if (!arst_n) begin
			key_word <= '0;
			iv_word <= '0;
			decrypt_on <= 1'b0;
			chain_word = '0;
			errors <= 0;
			blocks_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEY_HIGH: key_word[127:64] <= cfg_data;
					REG_KEY_LOW: key_word[63:0] <= cfg_data;
					REG_IV_HIGH: iv_word[127:64] <= cfg_data;
					REG_IV_LOW: iv_word[63:0] <= cfg_data;
					REG_DECRYPT: decrypt_on <= cfg_data[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				blocks_due.push_back(cbc_step({s_axis_tdata[63:0], s_axis_tdata[127:64]},
					s_axis_tdata[132:128], s_axis_tuser, s_axis_tlast));
			if (m_axis_tvalid && m_axis_tready) begin
				if (blocks_due.size() == 0) begin
					$display("%0t: result transaction with nothing expected: %h last %b",
						$realtime, m_axis_tdata, m_axis_tlast);
					errors <= errors + 1;
				end else begin
					want = blocks_due.pop_front();
					if (m_axis_tdata[63:0] !== want.res_hi || m_axis_tdata[127:64] !== want.res_lo
							|| m_axis_tlast !== want.res_last) begin
						$display("%0t: result mismatch: expected high %h low %h last %b, got high %h low %h last %b",
							$realtime, want.res_hi, want.res_lo, want.res_last,
							m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tlast);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// AES-128 CBC cipher unit testbench
// Drives keys, IVs and modes through the configuration channel and CBC
// messages through the block channel, with random idling on both streams.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import acu_pkg::*;

	// An index past the last register; the unit must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASES = 6;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [135:0]         s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 s_axis_tlast = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [127:0]         m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = '0;
	int                   errors;
	int                   pending;
	bit                   steady = 1'b0;
	int                   sink_hold = 0;
	int                   quiet_cycles = 0;

	always #5 clk = ~clk;

	aes128_cbc_cipher_unit uut (.*);

	aes128_cbc_cipher_checker checker_i (.*);

	// The result sink stalls in random bursts, except in the closing phase.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (!steady && $urandom_range(0, 9) == 0) begin
			sink_hold <= $urandom_range(0, 16);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog on cycles in which no transaction of any kind happens.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Registers change only once every outstanding block has come back.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Presents one block and returns at the edge where its transaction happens.
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic [4:0] nbytes,
			input logic first, input logic last);
		if (!steady && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tdata <= {3'b000, nbytes, lo, hi};
		s_axis_tuser <= first;
		s_axis_tlast <= last;
		s_axis_tvalid <= 1'b1;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// A short CBC message, or now and then a block with random flags.
	task automatic send_message();
		int len;
		logic [4:0] tail;
		if ($urandom_range(0, 9) == 0) begin
			send_block(rand64(), rand64(), 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else begin
			len = $urandom_range(1, 8);
			tail = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
			for (int i = 0; i < len; i++)
				send_block(rand64(), rand64(), (i == len - 1) ? tail : 5'd16, i == 0, i == len - 1);
		end
	endtask

	initial begin
		logic [63:0] kh, kl;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed blocks under the reset key and IV, encrypt mode.
		send_block('0, '0, 5'd16, 1'b1, 1'b0);
		send_block('1, '1, 5'd16, 1'b0, 1'b1);
		send_block('1, '1, 5'd0, 1'b1, 1'b1);
		send_block('1, '1, 5'd31, 1'b0, 1'b0);
		send_block('1, '1, 5'd17, 1'b0, 1'b0);
		for (int n = 1; n < 16; n += 3) send_block(rand64(), rand64(), 5'(n), 1'b0, n > 12);

		// Known vector: FIPS-197 key and plaintext with a zero IV.
		write_reg(REG_KEY_HIGH, 64'h0001020304050607);
		write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 1'b1, 1'b1);
		write_reg(REG_DECRYPT, 64'd1);
		send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 5'd16, 1'b1, 1'b1);
		send_block('1, '1, 5'd0, 1'b0, 1'b0);
		write_reg(REG_UNMAPPED, '1);
		send_block(rand64(), rand64(), 5'd16, 1'b0, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin kh = '1; kl = '1; end
				1: begin kh = '0; kl = '0; end
				default: begin kh = rand64(); kl = rand64(); end
			endcase
			write_reg(REG_KEY_HIGH, kh);
			write_reg(REG_KEY_LOW, kl);
			write_reg(REG_IV_HIGH, (ph == 0) ? '1 : (ph == 1) ? '0 : rand64());
			write_reg(REG_IV_LOW, (ph == 0) ? '1 : (ph == 1) ? '0 : rand64());
			write_reg(REG_DECRYPT, 64'(ph % 2));
			if (ph == PHASES - 1) steady = 1'b1;
			for (int sent = 0; sent < 26; sent++) send_message();
		end
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
+incdir+design
design/acu_pkg.sv
design/acu_ram.sv
design/aes128_cbc_cipher_unit.sv
tb/sv/aes128_cbc_cipher_checker.sv
tb/sv/tb.sv
